FILE: rtl/gwqs_pkg.sv
// ----------------------------------------------------------------------------
// gwqs_pkg - shared definitions for the grouped weighted quantile selector
// sizes, register map, sequencer codes and the store entry layout
// ----------------------------------------------------------------------------
package gwqs_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int MAX_GROUPS  = 16;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int GC_W        = 5;
  localparam int WSUM_W      = CNT_W + 16;
  localparam int PROD_W      = WSUM_W + 16;
  localparam int PADDR_W     = 5;

  // register byte addresses
  localparam logic [PADDR_W-1:0] REG_QFRAC = 5'h00;
  localparam logic [PADDR_W-1:0] REG_UPPER = 5'h04;
  localparam logic [PADDR_W-1:0] REG_DROP  = 5'h08;
  localparam logic [PADDR_W-1:0] REG_WMODE = 5'h0c;
  localparam logic [PADDR_W-1:0] REG_GCNT  = 5'h10;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_STAT  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_CAND  = 3'd3;
  localparam logic [2:0] ST_CLAT  = 3'd4;
  localparam logic [2:0] ST_INNER = 3'd5;
  localparam logic [2:0] ST_EVAL  = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  typedef struct packed {
    logic [31:0] value;
    logic [15:0] weight;
    logic        missing;
    logic [3:0]  group;
  } entry_t;

endpackage

FILE: rtl/gwqs_if.sv
// ----------------------------------------------------------------------------
// gwqs channel interfaces
// sample channel and result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface gwqs_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_value;
  logic               sample_missing;
  logic [3:0]         group_index;
  logic [15:0]        sample_weight;
  logic               last_sample;

  modport source (output valid, sample_value, sample_missing, group_index,
                  sample_weight, last_sample, input ready);
  modport sink   (input valid, sample_value, sample_missing, group_index,
                  sample_weight, last_sample, output ready);
endinterface

interface gwqs_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         result_group;
  logic signed [31:0] result_value;
  logic               result_missing;
  logic               result_last;

  modport source (output valid, result_group, result_value, result_missing,
                  result_last, input ready);
  modport sink   (input valid, result_group, result_value, result_missing,
                  result_last, output ready);
endinterface

FILE: rtl/grouped_weighted_quantile_select.sv
// ----------------------------------------------------------------------------
// grouped_weighted_quantile_select - per-group quantile over a sample store
// loads samples, then on the last one reports one quantile per group
// ----------------------------------------------------------------------------
//  channel   direction  transaction
//  in_ch     sink       one sample (value, missing, group, weight, last)
//  out_ch    source     one group result (group, value, missing, last)
//  cfg_*     apb slave  register write/read, pready always high
//
//  a sample without last is stored and in_ch stays ready; a sample with last
//  starts selection per group: statistics scan, multiply step, then for each
//  stored entry a candidate read, plus a rank scan if it is a kept sample of
//  the group, a closing step and the result (straight after the multiply step
//  if the group has no kept sample, or a missing one while drop is off); all
//  store reads share the single read port; rst_n is synchronous; the store
//  itself is not cleared, only its fill count; in_ch.ready is low from the
//  last sample until the final result is taken; a stalled result simply holds
module grouped_weighted_quantile_select (
  input  logic                          clk,
  input  logic                          rst_n,
  gwqs_in_if.sink                       in_ch,
  gwqs_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [gwqs_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int AW = gwqs_pkg::ADDR_W;
  localparam int CW = gwqs_pkg::CNT_W;
  localparam int WW = gwqs_pkg::WSUM_W;
  localparam int PW = gwqs_pkg::PROD_W;

  // configuration registers
  logic [15:0]             qfrac_r;
  logic                    upper_r;
  logic                    drop_r;
  logic                    wmode_r;
  logic [gwqs_pkg::GC_W-1:0] gcnt_r;

  // sequencer and datapath registers
  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [3:0]    grp_r, grp_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic          pvld_r, pvld_nxt;
  logic [CW-1:0] ptag_r, ptag_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [WW-1:0] wsum_r, wsum_nxt;
  logic          hmiss_r, hmiss_nxt;
  logic [PW-1:0] prod_r, prod_nxt;
  logic [CW-1:0] cand_r, cand_nxt;
  logic [31:0]   cval_r, cval_nxt;
  logic [CW-1:0] rank_r, rank_nxt;
  logic [WW-1:0] pref_r, pref_nxt;
  logic          found_r, found_nxt;
  logic [CW-1:0] brank_r, brank_nxt;
  logic [31:0]   best_r, best_nxt;
  logic [31:0]   oval_r, oval_nxt;
  logic          omiss_r, omiss_nxt;

  // sample store, one write and one registered read port
  gwqs_pkg::entry_t mem [gwqs_pkg::MAX_SAMPLES];
  gwqs_pkg::entry_t rd_r;
  gwqs_pkg::entry_t wr_entry;
  logic [AW-1:0]    raddr;
  logic             wr_en;

  logic                      in_xfer, out_xfer, cfg_wr;
  logic [gwqs_pkg::GC_W-1:0] gc;
  logic                      last_grp;
  logic                      rd_kept, rd_before, scan_done, pass;
  logic [WW-1:0]             mul_a;
  logic [PW-1:0]             lhs;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qfrac_r <= 16'd32768;
      upper_r <= 1'b0;
      drop_r  <= 1'b1;
      wmode_r <= 1'b0;
      gcnt_r  <= gwqs_pkg::GC_W'(1);
    end else if (cfg_wr) begin
      case (cfg_paddr)
        gwqs_pkg::REG_QFRAC: qfrac_r <= cfg_pwdata[15:0];
        gwqs_pkg::REG_UPPER: upper_r <= cfg_pwdata[0];
        gwqs_pkg::REG_DROP:  drop_r  <= cfg_pwdata[0];
        gwqs_pkg::REG_WMODE: wmode_r <= cfg_pwdata[0];
        gwqs_pkg::REG_GCNT:  gcnt_r  <= cfg_pwdata[gwqs_pkg::GC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      gwqs_pkg::REG_QFRAC: cfg_prdata = {16'd0, qfrac_r};
      gwqs_pkg::REG_UPPER: cfg_prdata = {31'd0, upper_r};
      gwqs_pkg::REG_DROP:  cfg_prdata = {31'd0, drop_r};
      gwqs_pkg::REG_WMODE: cfg_prdata = {31'd0, wmode_r};
      gwqs_pkg::REG_GCNT:  cfg_prdata = {{(32-gwqs_pkg::GC_W){1'b0}}, gcnt_r};
      default:             cfg_prdata = 32'd0;
    endcase
  end

  // group count clamped to 1..MAX_GROUPS
  always_comb begin
    if (gcnt_r == '0)
      gc = gwqs_pkg::GC_W'(1);
    else if (gcnt_r > gwqs_pkg::GC_W'(gwqs_pkg::MAX_GROUPS))
      gc = gwqs_pkg::GC_W'(gwqs_pkg::MAX_GROUPS);
    else
      gc = gcnt_r;
  end
  assign last_grp = ({1'b0, grp_r} + gwqs_pkg::GC_W'(1)) == gc;

  assign in_ch.ready = (state_r == gwqs_pkg::ST_IDLE);
  assign in_xfer     = in_ch.valid & in_ch.ready;
  assign out_xfer    = out_ch.valid & out_ch.ready;

  assign wr_en = in_xfer && (count_r < CW'(gwqs_pkg::MAX_SAMPLES)) &&
                 ({1'b0, in_ch.group_index} < 5'(gwqs_pkg::MAX_GROUPS));
  assign wr_entry.value   = in_ch.sample_value;
  assign wr_entry.weight  = in_ch.sample_weight;
  assign wr_entry.missing = in_ch.sample_missing;
  assign wr_entry.group   = in_ch.group_index;

  assign raddr = (state_r == gwqs_pkg::ST_CAND) ? cand_r[AW-1:0] : scan_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en)
      mem[count_r[AW-1:0]] <= wr_entry;
    rd_r <= mem[raddr];
  end

  // entry in the read register belongs to the current group and is kept
  assign rd_kept   = (rd_r.group == grp_r) && !rd_r.missing;
  // entry sorts ahead of the candidate (ties broken by arrival order)
  assign rd_before = ($signed(rd_r.value) < $signed(cval_r)) ||
                     ((rd_r.value == cval_r) && (ptag_r < cand_r));
  assign scan_done = (scan_r == count_r) && !pvld_r;

  // shared multiplier operand: weight sum, or n / n-1 for the rank
  always_comb begin
    if (wmode_r)
      mul_a = wsum_r;
    else if (upper_r)
      mul_a = WW'(n_r);
    else
      mul_a = WW'(n_r - CW'(1));
  end

  assign lhs = {pref_r, 16'd0};
  always_comb begin
    if (wmode_r)
      pass = upper_r ? (lhs <= prod_r) : (lhs < prod_r);
    else
      pass = rank_r <= prod_r[CW+15:16];
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    grp_nxt   = grp_r;
    scan_nxt  = scan_r;
    pvld_nxt  = 1'b0;
    ptag_nxt  = ptag_r;
    n_nxt     = n_r;
    wsum_nxt  = wsum_r;
    hmiss_nxt = hmiss_r;
    prod_nxt  = prod_r;
    cand_nxt  = cand_r;
    cval_nxt  = cval_r;
    rank_nxt  = rank_r;
    pref_nxt  = pref_r;
    found_nxt = found_r;
    brank_nxt = brank_r;
    best_nxt  = best_r;
    oval_nxt  = oval_r;
    omiss_nxt = omiss_r;

    // store scan pipeline, shared by statistics and rank passes
    if (state_r == gwqs_pkg::ST_STAT || state_r == gwqs_pkg::ST_INNER) begin
      if (scan_r < count_r) begin
        scan_nxt = scan_r + CW'(1);
        pvld_nxt = 1'b1;
        ptag_nxt = scan_r;
      end
    end

    case (state_r)
      gwqs_pkg::ST_IDLE: begin
        if (wr_en)
          count_nxt = count_r + CW'(1);
        if (in_xfer && in_ch.last_sample) begin
          state_nxt = gwqs_pkg::ST_STAT;
          grp_nxt   = '0;
          scan_nxt  = '0;
          n_nxt     = '0;
          wsum_nxt  = '0;
          hmiss_nxt = 1'b0;
        end
      end
      gwqs_pkg::ST_STAT: begin
        if (pvld_r && rd_r.group == grp_r) begin
          if (rd_r.missing) begin
            hmiss_nxt = 1'b1;
          end else begin
            n_nxt    = n_r + CW'(1);
            wsum_nxt = wsum_r + WW'(rd_r.weight);
          end
        end
        if (scan_done)
          state_nxt = gwqs_pkg::ST_MUL;
      end
      gwqs_pkg::ST_MUL: begin
        prod_nxt = PW'(mul_a * qfrac_r);
        if ((!drop_r && hmiss_r) || n_r == '0) begin
          oval_nxt  = '0;
          omiss_nxt = 1'b1;
          state_nxt = gwqs_pkg::ST_OUT;
        end else begin
          cand_nxt  = '0;
          found_nxt = 1'b0;
          state_nxt = gwqs_pkg::ST_CAND;
        end
      end
      gwqs_pkg::ST_CAND: begin
        if (cand_r == count_r) begin
          oval_nxt  = found_r ? best_r : 32'd0;
          omiss_nxt = !found_r;
          state_nxt = gwqs_pkg::ST_OUT;
        end else begin
          state_nxt = gwqs_pkg::ST_CLAT;
        end
      end
      gwqs_pkg::ST_CLAT: begin
        cval_nxt = rd_r.value;
        if (rd_kept) begin
          scan_nxt  = '0;
          rank_nxt  = '0;
          pref_nxt  = '0;
          state_nxt = gwqs_pkg::ST_INNER;
        end else begin
          cand_nxt  = cand_r + CW'(1);
          state_nxt = gwqs_pkg::ST_CAND;
        end
      end
      gwqs_pkg::ST_INNER: begin
        if (pvld_r && rd_kept && rd_before) begin
          rank_nxt = rank_r + CW'(1);
          pref_nxt = pref_r + WW'(rd_r.weight);
        end
        if (scan_done)
          state_nxt = gwqs_pkg::ST_EVAL;
      end
      gwqs_pkg::ST_EVAL: begin
        // taken values form a prefix of sorted order: keep the highest rank
        if (pass && (!found_r || rank_r > brank_r)) begin
          found_nxt = 1'b1;
          brank_nxt = rank_r;
          best_nxt  = cval_r;
        end
        cand_nxt  = cand_r + CW'(1);
        state_nxt = gwqs_pkg::ST_CAND;
      end
      gwqs_pkg::ST_OUT: begin
        if (out_xfer) begin
          if (last_grp) begin
            count_nxt = '0;
            state_nxt = gwqs_pkg::ST_IDLE;
          end else begin
            grp_nxt   = grp_r + 4'd1;
            scan_nxt  = '0;
            n_nxt     = '0;
            wsum_nxt  = '0;
            hmiss_nxt = 1'b0;
            state_nxt = gwqs_pkg::ST_STAT;
          end
        end
      end
      default: state_nxt = gwqs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gwqs_pkg::ST_IDLE;
      count_r <= '0;
      pvld_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pvld_r  <= pvld_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grp_r   <= grp_nxt;
    scan_r  <= scan_nxt;
    ptag_r  <= ptag_nxt;
    n_r     <= n_nxt;
    wsum_r  <= wsum_nxt;
    hmiss_r <= hmiss_nxt;
    prod_r  <= prod_nxt;
    cand_r  <= cand_nxt;
    cval_r  <= cval_nxt;
    rank_r  <= rank_nxt;
    pref_r  <= pref_nxt;
    brank_r <= brank_nxt;
    best_r  <= best_nxt;
    oval_r  <= oval_nxt;
    omiss_r <= omiss_nxt;
  end

  assign out_ch.valid          = (state_r == gwqs_pkg::ST_OUT);
  assign out_ch.result_group   = grp_r;
  assign out_ch.result_value   = oval_r;
  assign out_ch.result_missing = omiss_r;
  assign out_ch.result_last    = last_grp;

  // fill count never passes the store depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(gwqs_pkg::MAX_SAMPLES))
    else $error("sample count beyond store depth");

  // input and output never open at the same time
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while a result is shown");

  // the final result of a set empties the store
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_ch.result_last) |=> (count_r == '0 && in_ch.ready))
    else $error("store not emptied after final result");

  // a missing result always carries a zero value
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.result_missing) |-> (out_ch.result_value == 32'd0))
    else $error("missing result with nonzero value");

endmodule
